// File: src/rxff_pkg.sv
// Shared types and constants for the receive FIFO with XON/XOFF flow control.
`timescale 1ns / 1ps
`default_nettype none
package rxff_pkg;

	// Storage depth default
	localparam int unsigned FIFO_DEPTH_DEF = 32;

	// Command codes
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Register indexes
	localparam logic REG_HIGH_WM = 1'b0;
	localparam logic REG_LOW_WM  = 1'b1;

	// Register widths and reset values
	localparam int unsigned HWM_W = 6;
	localparam int unsigned LWM_W = 5;
	localparam int unsigned CFG_W = 6;
	localparam logic [HWM_W-1:0] HWM_RESET = 6'd20;
	localparam logic [LWM_W-1:0] LWM_RESET = 5'd4;

	// Flow control characters
	localparam logic [7:0] XON_CHAR  = 8'h11;
	localparam logic [7:0] XOFF_CHAR = 8'h13;

	// Status of one result word, registered in the control unit
	typedef struct packed {
		logic strobe;
		logic read_valid;
		logic flow_send;
		logic flow_xoff;
		logic overflow;
	} res_stat_t;

endpackage
`default_nettype wire

// File: src/rx_fifo_xon_xoff_flow_control_core.sv
// Top level of the receive byte FIFO with XON/XOFF software flow control.
//
//  channel   | handshake           | words
//  ----------+---------------------+------------------------------------------------
//  command   | start / busy        | cmd, byte_in
//  result    | done (strobe)       | read_data, read_valid, flow_send, flow_char,
//            |                     | fill_level, overflow
//  config    | wr_en               | wr_index, wr_data
//
// One word is taken per cycle; busy is never raised. The result of a word
// taken at one edge is on the result ports for the following cycle, set by
// the registered read of the byte store.
// Reset empties the FIFO, sets flow on and loads the default watermarks;
// the byte store itself is not cleared. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module rx_fifo_xon_xoff_flow_control_core import rxff_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             cmd,
	input  wire logic [7:0]       byte_in,
	input  wire logic             wr_en,
	input  wire logic             wr_index,
	input  wire logic [CFG_W-1:0] wr_data,
	output logic                  done,
	output logic      [7:0]       read_data,
	output logic                  read_valid,
	output logic                  flow_send,
	output logic      [7:0]       flow_char,
	output logic      [5:0]       fill_level,
	output logic                  overflow
);

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [HWM_W-1:0] hwm_q;
	logic [LWM_W-1:0] lwm_q;
	logic             accept;
	logic             ram_we, ram_re;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]       ram_rdata;
	logic [CNT_W-1:0] count;
	logic [CNT_W+5:0] count_ext;
	res_stat_t        stat;

	// Watermark registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwm_q <= HWM_RESET;
			lwm_q <= LWM_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HIGH_WM: hwm_q <= wr_data[HWM_W-1:0];
				REG_LOW_WM:  lwm_q <= wr_data[LWM_W-1:0];
				default:     ;
			endcase
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Control unit
	rxff_ctrl #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.high_wm   (hwm_q),
		.low_wm    (lwm_q),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.count     (count),
		.stat      (stat)
	);

	// Byte store
	rxff_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (byte_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result word
	assign count_ext  = {6'd0, count};
	assign done       = stat.strobe;
	assign read_valid = stat.read_valid;
	assign read_data  = stat.read_valid ? ram_rdata : 8'd0;
	assign flow_send  = stat.flow_send;
	assign flow_char  = !stat.flow_send ? 8'd0 : (stat.flow_xoff ? XOFF_CHAR : XON_CHAR);
	assign fill_level = count_ext[5:0];
	assign overflow   = stat.overflow;

`ifndef SYNTHESIS
	// A result strobe follows every accepted word and nothing else
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result strobe missing after accepted word");

	a_no_stray_done: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result strobe without accepted word");

	// A dropped byte only happens with the store full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow |-> (done && !read_valid && count == CNT_W'(FIFO_DEPTH)))
		else $error("overflow flagged while store not full");

	// The count never exceeds the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(FIFO_DEPTH))
		else $error("fill count above depth");
`endif

endmodule
`default_nettype wire

// File: src/rxff_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rxff_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/rxff_ctrl.sv
// Pointer, fill count and flow state control with the registered result status.
`timescale 1ns / 1ps
`default_nettype none
module rxff_ctrl import rxff_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF,
	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH),
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic             cmd,
	input  wire logic [HWM_W-1:0] high_wm,
	input  wire logic [LWM_W-1:0] low_wm,
	output logic                  ram_we,
	output logic      [PTR_W-1:0] ram_waddr,
	output logic                  ram_re,
	output logic      [PTR_W-1:0] ram_raddr,
	output logic      [CNT_W-1:0] count,
	output res_stat_t             stat
);

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
	localparam int unsigned      CMP_W    = CNT_W + HWM_W;

	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic             flow_on_q;
	logic             full, empty, wr_ok, rd_ok, xoff, xon;
	logic [CMP_W-1:0] cnt_cmp, hwm_cmp, lwm_cmp;
	res_stat_t        stat_q;

	// Occupancy and the effect of this word
	always_comb begin
		full    = (cnt_q == CNT_FULL);
		empty   = (cnt_q == '0);
		wr_ok   = accept && (cmd == CMD_STORE) && !full;
		rd_ok   = accept && (cmd == CMD_READ) && !empty;
		cnt_nxt = cnt_q;
		if (wr_ok) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end else if (rd_ok) begin
			cnt_nxt = cnt_q - CNT_W'(1);
		end
	end

	// Watermark compares on the level after this word
	always_comb begin
		cnt_cmp = CMP_W'(cnt_nxt);
		hwm_cmp = CMP_W'(high_wm);
		lwm_cmp = CMP_W'(low_wm);
		xoff    = accept && (cmd == CMD_STORE) && flow_on_q && (cnt_cmp >= hwm_cmp);
		xon     = accept && (cmd == CMD_READ) && !flow_on_q && (cnt_cmp <= lwm_cmp);
	end

	// RAM access this cycle
	assign ram_we    = wr_ok;
	assign ram_waddr = wptr_q;
	assign ram_re    = rd_ok;
	assign ram_raddr = rptr_q;

	// Pointers, count and flow state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= '0;
			rptr_q    <= '0;
			cnt_q     <= '0;
			flow_on_q <= 1'b1;
		end else begin
			cnt_q <= cnt_nxt;
			if (wr_ok) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
			end
			if (rd_ok) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
			end
			if (xoff) begin
				flow_on_q <= 1'b0;
			end else if (xon) begin
				flow_on_q <= 1'b1;
			end
		end
	end

	// Result status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
		end else begin
			stat_q.strobe     <= accept;
			stat_q.read_valid <= rd_ok;
			stat_q.flow_send  <= xoff || xon;
			stat_q.flow_xoff  <= xoff;
			stat_q.overflow   <= accept && (cmd == CMD_STORE) && full;
		end
	end

	assign count = cnt_q;
	assign stat  = stat_q;

endmodule
`default_nettype wire
